### design/pwsd_pkg.sv
// package for the pulse width symbol decoder
// holds counter widths, phase encoding, result and pulse class types, position code function
// no dependencies
`default_nettype none

package pwsd_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int NUM_SYMBOLS = 3;
    localparam int SYM_BITS    = 3;
    localparam int IDX_BITS    = 2;
    localparam int PLEN_BITS   = 8;
    localparam int BASE_OUT_BITS = 16;
    // room for 12 * count without overflow
    localparam int PROD_BITS   = COUNT_BITS + 4;

    localparam logic [PLEN_BITS-1:0] PREAMBLE_LEN_RESET = 8'd5;

    localparam logic [2:0] POS_INVALID = 3'd6;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        PH_BASE     = 2'd0,
        PH_DATA_PRE = 2'd1,
        PH_MEASURE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic glitch;
        logic bit_val;
        logic bad;
    } pulse_class_t;

    typedef struct packed {
        logic [SYM_BITS-1:0]      symbol_bits;
        logic [SYM_BITS-1:0]      symbol_bad;
        logic [2:0]               position_code;
        logic [BASE_OUT_BITS-1:0] base_width;
    } pwsd_result_t;

    function automatic logic [2:0] position_of(input logic [SYM_BITS-1:0] bits,
                                               input logic [SYM_BITS-1:0] bad);
        logic [2:0] code;
        code = POS_INVALID;
        if (bad == '0) begin
            unique case (bits)
                3'b000:  code = 3'd0;
                3'b001:  code = 3'd1;
                3'b010:  code = 3'd2;
                3'b100:  code = 3'd3;
                3'b101:  code = 3'd4;
                3'b110:  code = 3'd5;
                default: code = POS_INVALID;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### design/pwsd_classify.sv
// pulse classifier: compares a measured high pulse against the base width windows
// uses pwsd_pkg
`default_nettype none

module pwsd_classify (
    input  wire pwsd_pkg::count_t       pulse_len,
    input  wire pwsd_pkg::count_t       base_len,
    output pwsd_pkg::pulse_class_t      pulse_class
);
    import pwsd_pkg::*;

    logic [PROD_BITS-1:0] len_w;
    logic [PROD_BITS-1:0] base_w;
    logic [PROD_BITS-1:0] len_x5;
    logic [PROD_BITS-1:0] base_x4;
    logic [PROD_BITS-1:0] base_x6;
    logic [PROD_BITS-1:0] base_x8;
    logic [PROD_BITS-1:0] base_x12;
    logic                 win_zero;
    logic                 win_one;

    always_comb begin
        len_w    = {{(PROD_BITS-COUNT_BITS){1'b0}}, pulse_len};
        base_w   = {{(PROD_BITS-COUNT_BITS){1'b0}}, base_len};
        len_x5   = (len_w << 2) + len_w;
        base_x4  = base_w << 2;
        base_x6  = (base_w << 2) + (base_w << 1);
        base_x8  = base_w << 3;
        base_x12 = (base_w << 3) + (base_w << 2);

        win_zero = (len_x5 > base_x4) && (len_x5 < base_x6);
        win_one  = (len_x5 > base_x8) && (len_x5 < base_x12);

        // shorter than half the base is noise
        pulse_class.glitch  = (len_w << 1) < base_w;
        pulse_class.bit_val = !win_zero && win_one;
        pulse_class.bad     = !win_zero && !win_one;
    end

endmodule

`default_nettype wire

### design/pwsd_core.sv
// decoder state: preamble hunt, base width capture, symbol accumulation
// uses pwsd_pkg and pwsd_classify
`default_nettype none

module pwsd_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          step,
    input  wire                          level,
    input  wire [pwsd_pkg::PLEN_BITS-1:0] preamble_len,
    output logic                         res_valid,
    output pwsd_pkg::pwsd_result_t       res_data
);
    import pwsd_pkg::*;

    localparam count_t COUNT_MAX = '1;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_SYMBOLS - 1);

    phase_t               phase_reg, phase_next;
    count_t               run_length_reg, run_length_next;
    count_t               base_len_reg, base_len_next;
    logic [IDX_BITS-1:0]  symbol_index_reg, symbol_index_next;
    logic [SYM_BITS-1:0]  bits_so_far_reg, bits_so_far_next;
    logic [SYM_BITS-1:0]  bad_so_far_reg, bad_so_far_next;

    count_t               need;
    count_t               run_inc;
    logic [SYM_BITS-1:0]  bits_shift;
    logic [SYM_BITS-1:0]  bad_shift;
    pulse_class_t         pulse_class;

    pwsd_classify u_classify (
        .pulse_len   (run_length_reg),
        .base_len    (base_len_reg),
        .pulse_class (pulse_class)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_BASE;
            run_length_reg   <= '0;
            base_len_reg     <= '0;
            symbol_index_reg <= '0;
            bits_so_far_reg  <= '0;
            bad_so_far_reg   <= '0;
        end else begin
            phase_reg        <= phase_next;
            run_length_reg   <= run_length_next;
            base_len_reg     <= base_len_next;
            symbol_index_reg <= symbol_index_next;
            bits_so_far_reg  <= bits_so_far_next;
            bad_so_far_reg   <= bad_so_far_next;
        end
    end

    always_comb begin
        // a zero length acts as one
        need = (preamble_len == '0) ? count_t'(1)
                                    : {{(COUNT_BITS-PLEN_BITS){1'b0}}, preamble_len};
        run_inc    = (run_length_reg != COUNT_MAX) ? run_length_reg + 1'b1 : run_length_reg;
        bits_shift = {bits_so_far_reg[SYM_BITS-2:0], pulse_class.bit_val};
        bad_shift  = {bad_so_far_reg[SYM_BITS-2:0], pulse_class.bad};

        phase_next        = phase_reg;
        run_length_next   = run_length_reg;
        base_len_next     = base_len_reg;
        symbol_index_next = symbol_index_reg;
        bits_so_far_next  = bits_so_far_reg;
        bad_so_far_next   = bad_so_far_reg;

        res_valid              = 1'b0;
        res_data.symbol_bits   = bits_shift;
        res_data.symbol_bad    = bad_shift;
        res_data.position_code = position_of(bits_shift, bad_shift);
        res_data.base_width    = base_len_reg;

        if (step) begin
            unique case (phase_reg)
                PH_BASE, PH_DATA_PRE: begin
                    if (level) begin
                        run_length_next = run_inc;
                    end else begin
                        if (run_length_reg >= need) begin
                            if (phase_reg == PH_BASE) begin
                                base_len_next = run_length_reg;
                                phase_next    = PH_DATA_PRE;
                            end else begin
                                phase_next        = PH_MEASURE;
                                symbol_index_next = '0;
                                bits_so_far_next  = '0;
                                bad_so_far_next   = '0;
                            end
                        end
                        run_length_next = '0;
                    end
                end
                PH_MEASURE: begin
                    if (level) begin
                        run_length_next = run_inc;
                    end else if (run_length_reg != '0) begin
                        run_length_next = '0;
                        if (!pulse_class.glitch) begin
                            if (symbol_index_reg == LAST_IDX) begin
                                res_valid         = 1'b1;
                                phase_next        = PH_BASE;
                                symbol_index_next = '0;
                                bits_so_far_next  = '0;
                                bad_so_far_next   = '0;
                            end else begin
                                symbol_index_next = symbol_index_reg + 1'b1;
                                bits_so_far_next  = bits_shift;
                                bad_so_far_next   = bad_shift;
                            end
                        end
                    end
                end
                default: begin
                    // undefined phase falls back to the base hunt
                    phase_next      = PH_BASE;
                    run_length_next = level ? count_t'(1) : '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/pulse_width_symbol_decoder.sv
// Pulse width symbol decoder, top level: input register, decoder core, result register.
// The item that completes a result goes through the input register and the core into the result register.
// Throughput: one pin sample per cycle while the result register is empty or m_tready is high.
// While a result waits, the input register can still take one item; the core steps only once the result is taken.
// Reset (synchronous, active low): preamble_len returns to 5, the decoder hunts a base
// preamble with all counters cleared, both stage registers empty.
`default_nettype none

module pulse_width_symbol_decoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [0] pin_level, [7:1] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [2:0] symbol_bits, [5:3] symbol_bad,
                                    // [8:6] position_code, [24:9] base_width, [31:25] zero
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data    // preamble_len
);
    import pwsd_pkg::*;

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic                 out_valid_reg;
    pwsd_result_t         out_data_reg;
    logic [PLEN_BITS-1:0] preamble_len_reg;

    logic                 advance;
    logic                 res_valid;
    pwsd_result_t         res_data;

    pwsd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .level        (in_level_reg),
        .preamble_len (preamble_len_reg),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_data_reg.base_width, out_data_reg.position_code,
                        out_data_reg.symbol_bad, out_data_reg.symbol_bits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            preamble_len_reg <= PREAMBLE_LEN_RESET;
        end else begin
            if (cfg_valid) begin
                preamble_len_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (advance && res_valid) begin
            out_data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

### dv/tb_pulse_width_symbol_decoder.sv
// testbench for pulse_width_symbol_decoder: drives pin samples, writes preamble_len,
// predicts every decoded symbol set and compares it with the result stream
// depends on pwsd_pkg and the decoder top level
`default_nettype none

module tb_pulse_width_symbol_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pwsd_pkg::*;

    localparam int PIPE_LAT = 2;
    localparam int MAX_IDLE = 14;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [0] pin_level, [7:1] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [2:0] symbol_bits, [5:3] symbol_bad,
                                    // [8:6] position_code, [24:9] base_width, [31:25] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    pulse_width_symbol_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5ns aclk = ~aclk;

    int unsigned cycle_count = 0;
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[pulse_width_symbol_decoder] ERROR");
        $finish;
    end

    // decoder state as predicted from the accepted pin samples
    logic [PLEN_BITS-1:0] model_plen  = PREAMBLE_LEN_RESET;
    phase_t               model_phase = PH_BASE;
    count_t               model_run   = '0;
    count_t               model_base  = '0;
    logic [IDX_BITS-1:0]  model_idx   = '0;
    logic [SYM_BITS-1:0]  model_bits  = '0;
    logic [SYM_BITS-1:0]  model_bad   = '0;

    pwsd_result_t pending_sets[$];

    int unsigned samples_taken = 0;
    int unsigned sets_checked  = 0;
    int unsigned mismatches    = 0;

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned rx_hold = 0;

    function automatic logic [2:0] expected_position(input logic [SYM_BITS-1:0] bits,
                                                     input logic [SYM_BITS-1:0] bad);
        logic [2:0] code;
        code = POS_INVALID;
        if (bad == '0) begin
            case (bits)
                3'b000: code = 3'd0;
                3'b001: code = 3'd1;
                3'b010: code = 3'd2;
                3'b100: code = 3'd3;
                3'b101: code = 3'd4;
                3'b110: code = 3'd5;
                default: code = POS_INVALID;
            endcase
        end
        return code;
    endfunction

    function automatic void decode_sample(input logic level);
        count_t       need;
        int unsigned  len_u;
        int unsigned  base_u;
        logic         bit_v;
        logic         bad_v;
        pwsd_result_t set;
        need = count_t'(model_plen);
        if (need == '0) need = count_t'(1);
        if (model_phase != PH_BASE && model_phase != PH_DATA_PRE && model_phase != PH_MEASURE) begin
            model_phase = PH_BASE;
            model_run   = '0;
        end
        if (level) begin
            if (model_run != '1) model_run = model_run + 1'b1;
        end else if (model_phase == PH_BASE || model_phase == PH_DATA_PRE) begin
            if (model_run >= need) begin
                if (model_phase == PH_BASE) begin
                    model_base  = model_run;
                    model_phase = PH_DATA_PRE;
                end else begin
                    model_phase = PH_MEASURE;
                    model_idx   = '0;
                    model_bits  = '0;
                    model_bad   = '0;
                end
            end
            model_run = '0;
        end else if (model_run != '0) begin
            len_u     = 32'(model_run);
            base_u    = 32'(model_base);
            model_run = '0;
            // pulses under half the base are glitches
            if (2 * len_u >= base_u) begin
                bit_v = 1'b0;
                bad_v = 1'b0;
                if (5 * len_u > 4 * base_u && 5 * len_u < 6 * base_u) bit_v = 1'b0;
                else if (5 * len_u > 8 * base_u && 5 * len_u < 12 * base_u) bit_v = 1'b1;
                else bad_v = 1'b1;
                model_bits = {model_bits[SYM_BITS-2:0], bit_v};
                model_bad  = {model_bad[SYM_BITS-2:0], bad_v};
                model_idx  = model_idx + 1'b1;
                if (model_idx >= NUM_SYMBOLS) begin
                    set.symbol_bits   = model_bits;
                    set.symbol_bad    = model_bad;
                    set.position_code = expected_position(model_bits, model_bad);
                    set.base_width    = model_base;
                    pending_sets.push_back(set);
                    model_phase = PH_BASE;
                    model_idx   = '0;
                    model_bits  = '0;
                    model_bad   = '0;
                end
            end
        end
    endfunction

    function automatic void check_symbol_set(input logic [31:0] word);
        pwsd_result_t want;
        if (pending_sets.size() == 0) begin
            $error("symbol set with no prediction, tdata %h", word);
            mismatches++;
            return;
        end
        want = pending_sets.pop_front();
        sets_checked++;
        if (word[2:0] !== want.symbol_bits) begin
            $error("symbol_bits: expected %b, got %b", want.symbol_bits, word[2:0]);
            mismatches++;
        end
        if (word[5:3] !== want.symbol_bad) begin
            $error("symbol_bad: expected %b, got %b", want.symbol_bad, word[5:3]);
            mismatches++;
        end
        if (word[8:6] !== want.position_code) begin
            $error("position_code: expected %0d, got %0d", want.position_code, word[8:6]);
            mismatches++;
        end
        if (word[24:9] !== want.base_width) begin
            $error("base_width: expected %0d, got %0d", want.base_width, word[24:9]);
            mismatches++;
        end
        if (word[31:25] !== '0) begin
            $error("tdata pad: expected 0, got %h", word[31:25]);
            mismatches++;
        end
    endfunction

    // result check before prediction, so a set is never matched in its own cycle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_symbol_set(m_tdata);
            if (s_tvalid && s_tready) begin
                decode_sample(s_tdata[0]);
                samples_taken++;
            end
            if (cfg_valid && cfg_ready) model_plen = cfg_data;
        end
    end

    // result side: random stall per result, or one long hold when asked
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold != 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_pin(input logic level);
        int unsigned idle;
        idle = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_run(input logic level, input int unsigned count);
        repeat (count) send_pin(level);
    endtask

    task automatic send_pulse(input int unsigned width, input int unsigned lows);
        send_run(1'b1, width);
        send_run(1'b0, lows);
    endtask

    // input stops until every predicted set is out and the pipeline has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_sets.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_preamble(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_width(input int unsigned b);
        int unsigned lo0, hi0, lo1, hi1, w;
        lo0 = 4 * b / 5 + 1;
        hi0 = (6 * b + 4) / 5 - 1;
        lo1 = 8 * b / 5 + 1;
        hi1 = (12 * b + 4) / 5 - 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom_range(lo0, hi0);
            4, 5, 6, 7: w = $urandom_range(lo1, hi1);
            8: begin
                // just outside one of the window edges
                case ($urandom_range(0, 3))
                    0: w = lo0 - 1;
                    1: w = hi0 + 1;
                    2: w = lo1 - 1;
                    default: w = hi1 + 1;
                endcase
            end
            default: w = $urandom_range(1, 3 * b);
        endcase
        return (w == 0) ? 1 : w;
    endfunction

    task automatic send_frame(input int unsigned base, input int unsigned pre2);
        send_pulse(base, $urandom_range(1, 3));
        send_pulse(pre2, $urandom_range(1, 3));
        repeat (NUM_SYMBOLS) begin
            if (base >= 3 && $urandom_range(0, 7) == 0)
                send_pulse($urandom_range(1, (base - 1) / 2), 1);
            send_pulse(pick_width(base), $urandom_range(1, 3));
        end
    endtask

    task automatic test_default_preamble();
        // four highs are short of the reset length of 5, the hunt restarts
        send_pulse(4, 1);
        send_pulse(5, 1);
        send_pulse(5, 2);
        send_pulse(5, 1);
        send_pulse(10, 1);
        // exactly 0.8 of the base sits on the edge, so bad
        send_pulse(4, 1);
    endtask

    task automatic test_min_preamble();
        write_preamble(8'd1);
        send_pulse(3, 1);
        send_pulse(1, 1);
        send_pulse(1, 1);
        send_pulse(3, 1);
        send_pulse(6, 1);
        send_pulse(2, 1);
    endtask

    task automatic test_zero_preamble();
        write_preamble(8'd0);
        send_pulse(1, 1);
        send_pulse(1, 3);
        send_pulse(1, 4);
        send_pulse(2, 2);
        send_pulse(2, 1);
    endtask

    task automatic test_long_preamble();
        write_preamble(8'd32);
        send_pulse(31, 2);
        send_frame(32 + $urandom_range(0, 3), 32);
    endtask

    task automatic test_output_backpressure();
        write_preamble(8'd1);
        tx_idle = 1'b0;
        rx_hold = 400;
        repeat (15) send_frame(1, 1);
        // pause until every set is out, then go on
        wait_drained();
        repeat (5) send_frame(2, 1);
        tx_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned samples_start;
        int unsigned sets_start;
        int unsigned frames;
        int unsigned need;
        int unsigned pick;
        logic [7:0]  plen;
        samples_start = samples_taken;
        sets_start    = sets_checked;
        frames        = 0;
        plen          = 8'd1;
        while (samples_taken - samples_start < 300 || sets_checked - sets_start < 8) begin
            if (frames % 8 == 0) begin
                plen = 8'($urandom_range(0, 6));
                write_preamble(plen);
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            need = (plen == 0) ? 1 : plen;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(need + $urandom_range(0, 3), need + $urandom_range(0, 2));
            end else if (pick == 7 || need == 1) begin
                repeat ($urandom_range(1, 20)) send_pin(1'($urandom_range(0, 1)));
            end else if (pick == 8) begin
                send_pulse($urandom_range(1, need - 1), $urandom_range(1, 3));
            end else begin
                // second preamble cut short
                send_frame(need + $urandom_range(0, 3), $urandom_range(1, need - 1));
            end
            frames++;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_preamble();
        test_min_preamble();
        test_zero_preamble();
        test_long_preamble();
        test_output_backpressure();
        test_random_frames();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_sets.size() != 0) begin
            $error("%0d predicted symbol sets never came out", pending_sets.size());
            mismatches++;
        end
        $display("%0d pin samples sent, %0d symbol sets compared, %0d mismatches",
                 samples_taken, sets_checked, mismatches);
        $display("preamble lengths 0, 1, 5, 32 and random, glitches, window edges, long output hold");
        if (mismatches == 0) begin
            $display("[pulse_width_symbol_decoder] OK");
        end else begin
            $display("[pulse_width_symbol_decoder] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
